// File: design/ovmn_pkg.sv
// ----------------------------------------------------------------------------
// ovmn_pkg
// shared types and constants of the outline miter normal block
// ----------------------------------------------------------------------------
package ovmn_pkg;

  localparam int IDX_W   = 12;
  localparam int COORD_W = 32;
  localparam int EN_W    = 18;  // edge normal, signed q1.16
  localparam int NORM_W  = 20;  // miter normal, signed q2.16
  localparam int LEN_W   = 19;  // length cap, unsigned q2.16

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 19'd98304;

  // one node job handed from the front to the back
  typedef struct packed {
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [EN_W-1:0]    e1x;
    logic signed [EN_W-1:0]    e1y;
    logic signed [EN_W-1:0]    e2x;
    logic signed [EN_W-1:0]    e2y;
    logic                      last;
    logic                      too_short;
  } job_t;

endpackage

// File: design/outline_vertex_miter_normals.sv
// ----------------------------------------------------------------------------
// outline_vertex_miter_normals
// miter normals at the vertices of a closed polygon outline
// ----------------------------------------------------------------------------
// Vertices of a closed polygon stream in one word at a time (signed q15.16,
// tlast on the final vertex). For every vertex one node word comes out with
// its index, position and miter normal (signed q2.16, length capped by
// max_normal_len), once the edge leaving that vertex is known; the final
// vertex also releases its own node and then node 0, which carries tlast.
// A polygon that ends after one or two vertices yields a single word with
// too_short set. The front takes a vertex and forms the edge normal with a
// bit-serial square root and two bit-serial divides, so the time a vertex
// takes depends on how far the edge has to be normalized; a zero-length
// edge skips the root and the divides, the first vertex is only stored, and
// the final vertex adds one more edge normal for the closing edge. The back
// forms each miter normal with one square root and two divides, skipped when
// the two normals cancel or the word is too short. A four-deep job queue
// lets the front take the next vertex while the back is still working, and
// a held output word lets the back start on the next node while it waits
// for m_tready.
module outline_vertex_miter_normals #(
  parameter int MAX_VERTS = 4096
) (
  input  logic          clk,
  input  logic          rst,
  // vertex stream
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [63:0]   s_tdata,     // vert_x[31:0], vert_y[63:32]
  input  logic          s_tlast,     // is_last_vertex
  // node stream
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [119:0]  m_tdata,     // node_index[11:0], pos_x[43:12],
                                     // pos_y[75:44], norm_x[95:76],
                                     // norm_y[115:96], zero fill
  output logic [1:0]    m_tuser,     // degenerate[0], too_short[1]
  output logic          m_tlast,     // last_node
  // length cap register
  input  logic          cfg_wr_en,
  input  logic [18:0]   cfg_wr_data  // max_normal_len, unsigned q2.16
);

  logic [18:0]    max_len;
  logic           q_push, q_full, q_pop, q_empty;
  ovmn_pkg::job_t push_job, head_job;

  // length cap, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= ovmn_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  // vertex intake, polygon state and edge normals
  ovmn_front #(
    .MAX_VERTS(MAX_VERTS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .q_push  (q_push),
    .q_job   (push_job),
    .q_full  (q_full)
  );

  // node jobs waiting for the back end
  ovmn_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .head_job(head_job),
    .empty   (q_empty)
  );

  // miter normal and output word
  ovmn_back u_back (
    .clk     (clk),
    .rst     (rst),
    .max_len (max_len),
    .q_empty (q_empty),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

// File: design/ovmn_isqrt.sv
// ----------------------------------------------------------------------------
// ovmn_isqrt
// iterative floor square root of a 64-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module ovmn_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [5:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= val;
        r    <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        cnt  <= 6'd32;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          r   <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/ovmn_divu.sv
// ----------------------------------------------------------------------------
// ovmn_divu
// restoring unsigned 64 by 64 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ovmn_divu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] rem;
  logic [63:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] shifted;

  assign shifted = {rem, quo[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= num;
        dsr  <= den;
        cnt  <= 7'd64;
        busy <= 1'b1;
      end else if (busy) begin
        if (shifted >= {1'b0, dsr}) begin
          rem <= 64'(shifted - {1'b0, dsr});
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= shifted[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/ovmn_queue.sv
// ----------------------------------------------------------------------------
// ovmn_queue
// four-entry job queue between front and back
// ----------------------------------------------------------------------------
module ovmn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ovmn_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output ovmn_pkg::job_t head_job,
  output logic          empty
);

  ovmn_pkg::job_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  assign full     = (fill == 3'd4);
  assign empty    = (fill == 3'd0);
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 2'd1;
      if (pop && !empty) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'b0, (push && !full)} - {2'b0, (pop && !empty)};
    end
  end

endmodule

// File: design/ovmn_front.sv
// ----------------------------------------------------------------------------
// ovmn_front
// takes vertices, keeps polygon state, forms edge normals and queues node jobs
// ----------------------------------------------------------------------------
module ovmn_front #(
  parameter int MAX_VERTS = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [63:0]    s_tdata,
  input  logic           s_tlast,
  output logic           q_push,
  output ovmn_pkg::job_t q_job,
  input  logic           q_full
);

  localparam int CW = $clog2(MAX_VERTS);

  localparam logic [3:0] F_IDLE    = 4'd0;
  localparam logic [3:0] F_SETUP   = 4'd1;
  localparam logic [3:0] F_NORM    = 4'd2;
  localparam logic [3:0] F_SQA     = 4'd3;
  localparam logic [3:0] F_SQB     = 4'd4;
  localparam logic [3:0] F_SQRT_GO = 4'd5;
  localparam logic [3:0] F_SQRT    = 4'd6;
  localparam logic [3:0] F_DIVA_GO = 4'd7;
  localparam logic [3:0] F_DIVA    = 4'd8;
  localparam logic [3:0] F_DIVB_GO = 4'd9;
  localparam logic [3:0] F_DIVB    = 4'd10;
  localparam logic [3:0] F_EDGE    = 4'd11;
  localparam logic [3:0] F_PUSH_A  = 4'd12;
  localparam logic [3:0] F_PUSH_B  = 4'd13;
  localparam logic [3:0] F_PUSH_C  = 4'd14;
  localparam logic [3:0] F_SHORT   = 4'd15;

  logic [3:0]  state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic        vlast;
  logic        phase;
  logic signed [31:0] vx, vy, first_vx, first_vy, prev_vx, prev_vy;
  logic signed [17:0] first_enx, first_eny, prev_enx, prev_eny, enx, eny;
  logic [32:0] a, b;
  logic        dx_pos, dy_neg;
  logic [61:0] sq_a, sq_b;
  logic [31:0] len;
  logic [16:0] ua;

  logic signed [31:0] x0, y0, x1, y1;
  logic [32:0] dx, dy, a_in, b_in, ab_or;
  logic        last_eff;
  logic        sqrt_start, sqrt_done, div_start, div_done;
  logic [63:0] sqrt_val, div_num, div_den, div_quo;
  logic [31:0] sqrt_root;
  logic [16:0] ub;

  assign x0 = phase ? vx : prev_vx;
  assign y0 = phase ? vy : prev_vy;
  assign x1 = phase ? first_vx : vx;
  assign y1 = phase ? first_vy : vy;
  assign dx = {x1[31], x1} - {x0[31], x0};
  assign dy = {y1[31], y1} - {y0[31], y0};
  assign a_in  = dx[32] ? -dx : dx;
  assign b_in  = dy[32] ? -dy : dy;
  assign ab_or = a | b;
  assign last_eff = s_tlast || (count >= CW'(MAX_VERTS - 1));
  assign ub = div_quo[16:0];

  assign s_tready   = (state == F_IDLE);
  assign sqrt_start = (state == F_SQRT_GO);
  assign sqrt_val   = {2'b0, sq_a} + {2'b0, sq_b};
  assign div_start  = (state == F_DIVA_GO) || (state == F_DIVB_GO);
  assign div_num    = (state == F_DIVA_GO) ? ({17'b0, a[30:0], 16'b0} + {33'b0, len[31:1]})
                                           : ({17'b0, b[30:0], 16'b0} + {33'b0, len[31:1]});
  assign div_den    = {32'b0, len};

  ovmn_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .val  (sqrt_val),
    .done (sqrt_done),
    .root (sqrt_root)
  );

  ovmn_divu u_divu (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // job composition per push state
  always_comb begin
    q_job  = '0;
    q_push = 1'b0;
    case (state)
      F_PUSH_A: begin
        q_push    = 1'b1;
        q_job.idx = ovmn_pkg::IDX_W'(idx - CW'(1));
        q_job.px  = prev_vx;
        q_job.py  = prev_vy;
        q_job.e1x = prev_enx;
        q_job.e1y = prev_eny;
        q_job.e2x = enx;
        q_job.e2y = eny;
      end
      F_PUSH_B: begin
        q_push    = 1'b1;
        q_job.idx = ovmn_pkg::IDX_W'(idx);
        q_job.px  = vx;
        q_job.py  = vy;
        q_job.e1x = prev_enx;
        q_job.e1y = prev_eny;
        q_job.e2x = enx;
        q_job.e2y = eny;
      end
      F_PUSH_C: begin
        q_push     = 1'b1;
        q_job.px   = first_vx;
        q_job.py   = first_vy;
        q_job.e1x  = enx;
        q_job.e1y  = eny;
        q_job.e2x  = first_enx;
        q_job.e2y  = first_eny;
        q_job.last = 1'b1;
      end
      F_SHORT: begin
        q_push          = 1'b1;
        q_job.last      = 1'b1;
        q_job.too_short = 1'b1;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      count     <= '0;
      phase     <= 1'b0;
      first_vx  <= '0;
      first_vy  <= '0;
      prev_vx   <= '0;
      prev_vy   <= '0;
      first_enx <= '0;
      first_eny <= '0;
      prev_enx  <= '0;
      prev_eny  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            vx    <= s_tdata[31:0];
            vy    <= s_tdata[63:32];
            vlast <= last_eff;
            idx   <= count;
            phase <= 1'b0;
            if (count == '0) begin
              first_vx <= s_tdata[31:0];
              first_vy <= s_tdata[63:32];
              prev_vx  <= s_tdata[31:0];
              prev_vy  <= s_tdata[63:32];
              if (last_eff) begin
                count <= '0;
                state <= F_SHORT;
              end else begin
                count <= CW'(1);
              end
            end else begin
              state <= F_SETUP;
            end
          end
        end
        F_SETUP: begin
          a      <= a_in;
          b      <= b_in;
          dx_pos <= !dx[32] && (dx != '0);
          dy_neg <= dy[32];
          if (a_in == '0 && b_in == '0) begin
            enx   <= '0;
            eny   <= '0;
            state <= F_EDGE;
          end else begin
            state <= F_NORM;
          end
        end
        F_NORM: begin
          if (ab_or[32:31] != 2'b0) begin
            a     <= a >> 1;
            b     <= b >> 1;
            state <= F_SQA;
          end else if (ab_or[32:30] == 3'b0) begin
            a <= a << 1;
            b <= b << 1;
          end else begin
            state <= F_SQA;
          end
        end
        F_SQA: begin
          sq_a  <= 62'(a[30:0]) * 62'(a[30:0]);
          state <= F_SQB;
        end
        F_SQB: begin
          sq_b  <= 62'(b[30:0]) * 62'(b[30:0]);
          state <= F_SQRT_GO;
        end
        F_SQRT_GO: state <= F_SQRT;
        F_SQRT: begin
          if (sqrt_done) begin
            len   <= sqrt_root;
            state <= F_DIVA_GO;
          end
        end
        F_DIVA_GO: state <= F_DIVA;
        F_DIVA: begin
          if (div_done) begin
            ua    <= div_quo[16:0];
            state <= F_DIVB_GO;
          end
        end
        F_DIVB_GO: state <= F_DIVB;
        F_DIVB: begin
          if (div_done) begin
            enx   <= dy_neg ? -$signed({1'b0, ub}) : $signed({1'b0, ub});
            eny   <= dx_pos ? -$signed({1'b0, ua}) : $signed({1'b0, ua});
            state <= F_EDGE;
          end
        end
        F_EDGE: begin
          if (phase) begin
            state <= F_PUSH_B;
          end else if (idx == CW'(1)) begin
            first_enx <= enx;
            first_eny <= eny;
            if (vlast) begin
              count <= '0;
              state <= F_SHORT;
            end else begin
              prev_vx  <= vx;
              prev_vy  <= vy;
              prev_enx <= enx;
              prev_eny <= eny;
              count    <= idx + CW'(1);
              state    <= F_IDLE;
            end
          end else begin
            state <= F_PUSH_A;
          end
        end
        F_PUSH_A: begin
          if (!q_full) begin
            prev_vx  <= vx;
            prev_vy  <= vy;
            prev_enx <= enx;
            prev_eny <= eny;
            if (vlast) begin
              phase <= 1'b1;
              state <= F_SETUP;
            end else begin
              count <= idx + CW'(1);
              state <= F_IDLE;
            end
          end
        end
        F_PUSH_B: begin
          if (!q_full) state <= F_PUSH_C;
        end
        F_PUSH_C: begin
          if (!q_full) begin
            count <= '0;
            state <= F_IDLE;
          end
        end
        F_SHORT: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: design/ovmn_back.sv
// ----------------------------------------------------------------------------
// ovmn_back
// turns node jobs into miter normals and holds the output word
// ----------------------------------------------------------------------------
module ovmn_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [18:0]    max_len,
  input  logic           q_empty,
  input  ovmn_pkg::job_t q_job,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [119:0]   m_tdata,
  output logic [1:0]     m_tuser,
  output logic           m_tlast
);

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_SQA    = 4'd1;
  localparam logic [3:0] B_SQB    = 4'd2;
  localparam logic [3:0] B_Q      = 4'd3;
  localparam logic [3:0] B_SQRT   = 4'd4;
  localparam logic [3:0] B_CAP    = 4'd5;
  localparam logic [3:0] B_MUL    = 4'd6;
  localparam logic [3:0] B_DIV_GO = 4'd7;
  localparam logic [3:0] B_DIV    = 4'd8;
  localparam logic [3:0] B_OUT    = 4'd9;

  logic [3:0]  state;
  ovmn_pkg::job_t job;
  logic [17:0] ax, ay;
  logic        sx_neg, sy_neg, degen, ycomp, capped;
  logic [35:0] qa, qb, q;
  logic [30:0] r;
  logic [49:0] mr;
  logic [36:0] pm;
  logic [18:0] mag_x, mag_y;

  logic signed [18:0] sx, sy;
  logic [17:0] ax_in, ay_in, a_sel;
  logic [35:0] q_sum;
  logic        sqrt_start, sqrt_done, div_start, div_done;
  logic [63:0] div_num, div_den, div_quo;
  logic [31:0] sqrt_root;
  logic [18:0] mag_sat;
  logic [19:0] nx, ny;

  assign sx    = 19'(q_job.e1x) + 19'(q_job.e2x);
  assign sy    = 19'(q_job.e1y) + 19'(q_job.e2y);
  assign ax_in = 18'(sx[18] ? -sx : sx);
  assign ay_in = 18'(sy[18] ? -sy : sy);
  assign q_sum = qa + qb;
  assign a_sel = ycomp ? ay : ax;
  assign q_pop = (state == B_IDLE) && !q_empty;

  assign sqrt_start = (state == B_Q) && (q_sum != '0);
  assign div_start  = (state == B_DIV_GO);
  assign div_num    = capped ? ({14'b0, pm, 13'b0} + {34'b0, r[30:1]})
                             : ({13'b0, a_sel, 33'b0} + {29'b0, q[35:1]});
  assign div_den    = capped ? {33'b0, r} : {28'b0, q};
  assign mag_sat    = (div_quo[63:19] != '0) ? 19'h7FFFF : div_quo[18:0];
  assign nx = sx_neg ? -{1'b0, mag_x} : {1'b0, mag_x};
  assign ny = sy_neg ? -{1'b0, mag_y} : {1'b0, mag_y};

  ovmn_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .val  ({2'b0, q_sum, 26'b0}),
    .done (sqrt_done),
    .root (sqrt_root)
  );

  ovmn_divu u_divu (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != B_OUT)) m_tvalid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            job    <= q_job;
            ax     <= ax_in;
            ay     <= ay_in;
            sx_neg <= sx[18];
            sy_neg <= sy[18];
            degen  <= (q_job.e1x == '0 && q_job.e1y == '0) ||
                      (q_job.e2x == '0 && q_job.e2y == '0) ||
                      (sx == '0 && sy == '0);
            mag_x  <= '0;
            mag_y  <= '0;
            ycomp  <= 1'b0;
            state  <= q_job.too_short ? B_OUT : B_SQA;
          end
        end
        B_SQA: begin
          qa    <= 36'(ax) * 36'(ax);
          state <= B_SQB;
        end
        B_SQB: begin
          qb    <= 36'(ay) * 36'(ay);
          state <= B_Q;
        end
        B_Q: begin
          q     <= q_sum;
          state <= (q_sum == '0) ? B_OUT : B_SQRT;
        end
        B_SQRT: begin
          if (sqrt_done) begin
            r     <= sqrt_root[30:0];
            state <= B_CAP;
          end
        end
        B_CAP: begin
          mr    <= 50'(max_len) * 50'(r);
          state <= B_MUL;
        end
        B_MUL: begin
          capped <= (mr[49:46] == 4'b0);
          pm     <= 37'(a_sel) * 37'(max_len);
          state  <= B_DIV_GO;
        end
        B_DIV_GO: state <= B_DIV;
        B_DIV: begin
          if (div_done) begin
            if (ycomp) begin
              mag_y <= mag_sat;
              state <= B_OUT;
            end else begin
              mag_x <= mag_sat;
              ycomp <= 1'b1;
              state <= B_MUL;
            end
          end
        end
        B_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, ny, nx, job.py, job.px, job.idx};
            m_tuser  <= {job.too_short, degen && !job.too_short};
            m_tlast  <= job.last;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
